@@ rtl/core/kvt_pkg.sv @@
`default_nettype none

package kvt_pkg;

  localparam int MAX_DEPTH     = 32;
  localparam int POSITION_BITS = 16;
  localparam int LEVEL_BITS    = $clog2(MAX_DEPTH);
  localparam int OFFSET_W      = 16;
  localparam int NEST_W        = 6;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [LEVEL_BITS-1:0]    level_t;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_QUOTE,
    CLS_OPEN_OBJ,
    CLS_OPEN_LIST,
    CLS_CLOSE_OBJ,
    CLS_CLOSE_LIST,
    CLS_OTHER
  } cls_t;

  typedef enum logic [2:0] {
    CTX_EXPECT_KEY,
    CTX_READ_KEY,
    CTX_EXPECT_VALUE,
    CTX_READ_VALUE,
    CTX_HALTED
  } ctx_t;

  typedef enum logic [2:0] {
    KIND_KEY,
    KIND_VALUE,
    KIND_OPEN_OBJ,
    KIND_OPEN_LIST,
    KIND_CLOSE_OBJ,
    KIND_CLOSE_LIST,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_TOP_CLOSE,
    ERR_DEPTH,
    ERR_BRACKET
  } err_t;

  typedef struct packed {
    logic restart;
    cls_t cls;
  } item_t;

  typedef struct packed {
    kind_t               kind;
    logic [OFFSET_W-1:0] offset;
    logic [OFFSET_W-1:0] length;
    logic [NEST_W-1:0]   depth;
    err_t                code;
  } event_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: r = CLS_SPACE;
      CH_QUOTE:                       r = CLS_QUOTE;
      CH_LBRACE:                      r = CLS_OPEN_OBJ;
      CH_LBRACK:                      r = CLS_OPEN_LIST;
      CH_RBRACE:                      r = CLS_CLOSE_OBJ;
      CH_RBRACK:                      r = CLS_CLOSE_LIST;
      default:                        r = CLS_OTHER;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/keyvalues_tokenizer_top.sv @@
// A result item passes through the input queue and the result buffer before it reaches the result ports.
// Throughput: one byte per cycle while the result buffer has room, set by the state update in the back end.
// A two-item queue on each side keeps input acceptance going while results wait.
// Reset (rst, synchronous) empties both queues and returns the tokenizer to expecting a key.
// The restart field clears the tokenizer state in-band before its own byte.
`default_nettype none

module keyvalues_tokenizer_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            restart,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [2:0]                           kind,
  output logic [kvt_pkg::OFFSET_W-1:0]         token_offset,
  output logic [kvt_pkg::OFFSET_W-1:0]         token_length,
  output logic [kvt_pkg::NEST_W-1:0]           nesting_depth,
  output logic [1:0]                           error_code
);

  logic            head_valid;
  kvt_pkg::item_t  head;
  logic            head_take;
  kvt_pkg::event_t result;

  kvt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .data_byte  (data_byte),
    .restart    (restart),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .head_take  (head_take)
  );

  kvt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_take  (head_take),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

  assign kind          = result.kind;
  assign token_offset  = result.offset;
  assign token_length  = result.length;
  assign nesting_depth = result.depth;
  assign error_code    = result.code;

endmodule

`default_nettype wire

@@ rtl/core/kvt_front.sv @@
`default_nettype none

module kvt_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire logic [7:0]      data_byte,
  input  wire logic            restart,
  output logic                 full,
  output logic                 head_valid,
  output kvt_pkg::item_t       head,
  input  wire logic            head_take
);

  kvt_pkg::item_t slot [2];
  logic           wp;
  logic           rp;
  logic [1:0]     count;
  logic           wr;
  logic           rd;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rp];
  assign wr         = push && !full;
  assign rd         = head_take && head_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wp] <= '{restart: restart, cls: kvt_pkg::classify(data_byte)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("front queue count out of range");

endmodule

`default_nettype wire

@@ rtl/core/kvt_back.sv @@
`default_nettype none

module kvt_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire kvt_pkg::item_t  head,
  output logic                 head_take,
  input  wire logic            pop,
  output logic                 empty,
  output kvt_pkg::event_t      result
);

  kvt_pkg::ctx_t                   ctx;
  kvt_pkg::ctx_t                   ctx_next;
  logic                            quoted;
  logic                            quoted_next;
  kvt_pkg::pos_t                   pos;
  kvt_pkg::pos_t                   pos_next;
  kvt_pkg::pos_t                   tbegin;
  kvt_pkg::pos_t                   tbegin_next;
  kvt_pkg::level_t                 level;
  kvt_pkg::level_t                 level_next;
  logic                            cur_list;
  logic                            cur_list_next;
  logic [kvt_pkg::MAX_DEPTH-1:0]   stack;

  kvt_pkg::ctx_t                   ctx_e;
  logic                            quoted_e;
  kvt_pkg::pos_t                   pos_e;
  kvt_pkg::pos_t                   tbegin_e;
  kvt_pkg::level_t                 level_e;
  logic                            cur_list_e;
  logic                            parent_list;
  logic                            ends;

  logic                            stack_we;
  kvt_pkg::level_t                 stack_wa;
  logic                            stack_wd;

  logic                            ev_valid;
  kvt_pkg::event_t                 ev;

  kvt_pkg::event_t                 obuf [2];
  logic                            owp;
  logic                            orp;
  logic [1:0]                      ocount;
  logic                            owr;
  logic                            ord;

  assign head_take = head_valid && (ocount != 2'd2);

  assign ctx_e      = head.restart ? kvt_pkg::CTX_EXPECT_KEY : ctx;
  assign quoted_e   = head.restart ? 1'b0 : quoted;
  assign pos_e      = head.restart ? '0 : pos;
  assign tbegin_e   = head.restart ? '0 : tbegin;
  assign level_e    = head.restart ? '0 : level;
  assign cur_list_e = head.restart ? 1'b0 : cur_list;

  assign parent_list = stack[level_e - 1'b1];
  assign ends = quoted_e ? (head.cls == kvt_pkg::CLS_QUOTE) : (head.cls == kvt_pkg::CLS_SPACE);

  always_comb begin
    ctx_next      = ctx;
    quoted_next   = quoted;
    pos_next      = pos;
    tbegin_next   = tbegin;
    level_next    = level;
    cur_list_next = cur_list;
    stack_we      = 1'b0;
    stack_wa      = level_e + 1'b1;
    stack_wd      = 1'b0;
    ev_valid      = 1'b0;
    ev            = '0;
    ev.offset     = kvt_pkg::OFFSET_W'(pos_e);
    if (head_take) begin
      ctx_next      = ctx_e;
      quoted_next   = quoted_e;
      pos_next      = pos_e;
      tbegin_next   = tbegin_e;
      level_next    = level_e;
      cur_list_next = cur_list_e;
      if (ctx_e != kvt_pkg::CTX_HALTED) begin
        if (pos_e == '1) begin
          ctx_next = kvt_pkg::CTX_HALTED;
          ev_valid = 1'b1;
          ev.kind  = kvt_pkg::KIND_ERROR;
          ev.code  = kvt_pkg::ERR_BRACKET;
        end else begin
          pos_next = pos_e + 1'b1;
          case (ctx_e)
            kvt_pkg::CTX_EXPECT_KEY: begin
              if (head.cls == kvt_pkg::CLS_CLOSE_OBJ) begin
                ev_valid = 1'b1;
                if (level_e == '0) begin
                  ctx_next = kvt_pkg::CTX_HALTED;
                  ev.kind  = kvt_pkg::KIND_ERROR;
                  ev.code  = kvt_pkg::ERR_TOP_CLOSE;
                end else begin
                  level_next    = level_e - 1'b1;
                  cur_list_next = parent_list;
                  ctx_next      = parent_list ? kvt_pkg::CTX_EXPECT_VALUE
                                              : kvt_pkg::CTX_EXPECT_KEY;
                  ev.kind       = kvt_pkg::KIND_CLOSE_OBJ;
                end
              end else if (head.cls != kvt_pkg::CLS_SPACE) begin
                quoted_next = (head.cls == kvt_pkg::CLS_QUOTE);
                tbegin_next = (head.cls == kvt_pkg::CLS_QUOTE) ? pos_e + 1'b1 : pos_e;
                ctx_next    = kvt_pkg::CTX_READ_KEY;
              end
            end
            kvt_pkg::CTX_EXPECT_VALUE: begin
              if (head.cls == kvt_pkg::CLS_CLOSE_LIST) begin
                ev_valid = 1'b1;
                if (!cur_list_e || level_e == '0) begin
                  ctx_next = kvt_pkg::CTX_HALTED;
                  ev.kind  = kvt_pkg::KIND_ERROR;
                  ev.code  = kvt_pkg::ERR_BRACKET;
                end else begin
                  level_next    = level_e - 1'b1;
                  cur_list_next = parent_list;
                  ctx_next      = parent_list ? kvt_pkg::CTX_EXPECT_VALUE
                                              : kvt_pkg::CTX_EXPECT_KEY;
                  ev.kind       = kvt_pkg::KIND_CLOSE_LIST;
                end
              end else if (head.cls == kvt_pkg::CLS_OPEN_OBJ ||
                           head.cls == kvt_pkg::CLS_OPEN_LIST) begin
                ev_valid = 1'b1;
                if (level_e == kvt_pkg::LEVEL_BITS'(kvt_pkg::MAX_DEPTH - 1)) begin
                  ctx_next = kvt_pkg::CTX_HALTED;
                  ev.kind  = kvt_pkg::KIND_ERROR;
                  ev.code  = kvt_pkg::ERR_DEPTH;
                end else begin
                  level_next    = level_e + 1'b1;
                  stack_we      = 1'b1;
                  stack_wd      = (head.cls == kvt_pkg::CLS_OPEN_LIST);
                  cur_list_next = (head.cls == kvt_pkg::CLS_OPEN_LIST);
                  quoted_next   = 1'b0;
                  if (head.cls == kvt_pkg::CLS_OPEN_OBJ) begin
                    ctx_next = kvt_pkg::CTX_EXPECT_KEY;
                    ev.kind  = kvt_pkg::KIND_OPEN_OBJ;
                  end else begin
                    ctx_next = kvt_pkg::CTX_EXPECT_VALUE;
                    ev.kind  = kvt_pkg::KIND_OPEN_LIST;
                  end
                end
              end else if (head.cls != kvt_pkg::CLS_SPACE) begin
                quoted_next = (head.cls == kvt_pkg::CLS_QUOTE);
                tbegin_next = (head.cls == kvt_pkg::CLS_QUOTE) ? pos_e + 1'b1 : pos_e;
                ctx_next    = kvt_pkg::CTX_READ_VALUE;
              end
            end
            kvt_pkg::CTX_READ_KEY: begin
              if (ends) begin
                ev_valid    = 1'b1;
                quoted_next = 1'b0;
                ctx_next    = kvt_pkg::CTX_EXPECT_VALUE;
                ev.kind     = kvt_pkg::KIND_KEY;
                ev.offset   = kvt_pkg::OFFSET_W'(tbegin_e);
                ev.length   = kvt_pkg::OFFSET_W'(pos_e - tbegin_e);
              end
            end
            kvt_pkg::CTX_READ_VALUE: begin
              if (ends) begin
                ev_valid    = 1'b1;
                quoted_next = 1'b0;
                ctx_next    = cur_list_e ? kvt_pkg::CTX_EXPECT_VALUE
                                         : kvt_pkg::CTX_EXPECT_KEY;
                ev.kind     = kvt_pkg::KIND_VALUE;
                ev.offset   = kvt_pkg::OFFSET_W'(tbegin_e);
                ev.length   = kvt_pkg::OFFSET_W'(pos_e - tbegin_e);
              end
            end
            default: begin
              ctx_next = kvt_pkg::CTX_HALTED;
            end
          endcase
        end
      end
    end
    ev.depth = kvt_pkg::NEST_W'(level_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx      <= kvt_pkg::CTX_EXPECT_KEY;
      quoted   <= 1'b0;
      pos      <= '0;
      tbegin   <= '0;
      level    <= '0;
      cur_list <= 1'b0;
      stack    <= '0;
    end else begin
      ctx      <= ctx_next;
      quoted   <= quoted_next;
      pos      <= pos_next;
      tbegin   <= tbegin_next;
      level    <= level_next;
      cur_list <= cur_list_next;
      if (stack_we) stack[stack_wa] <= stack_wd;
    end
  end

  assign owr    = head_take && ev_valid;
  assign ord    = pop && !empty;
  assign empty  = (ocount == 2'd0);
  assign result = obuf[orp];

  always_ff @(posedge clk) begin
    if (owr) begin
      obuf[owp] <= ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp    <= 1'b0;
      orp    <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (owr) owp <= ~owp;
      if (ord) orp <= ~orp;
      ocount <= ocount + {1'b0, owr} - {1'b0, ord};
    end
  end

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (owr && ev.kind == kvt_pkg::KIND_ERROR) |=> ctx == kvt_pkg::CTX_HALTED)
    else $error("error item without halt");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    (head_take && ctx == kvt_pkg::CTX_HALTED && !head.restart) |-> !ev_valid)
    else $error("item produced while halted");

  a_top_is_object: assert property (@(posedge clk) disable iff (rst)
    (level == '0) |-> !cur_list)
    else $error("top level marked as list");

  a_obuf_bound: assert property (@(posedge clk) disable iff (rst)
    ocount != 2'd3) else $error("result buffer count out of range");

endmodule

`default_nettype wire
